// ===== hdl/ctf_pkg.sv =====
// ctf_pkg: shared types, constants and the CORDIC arctangent table
// for the complementary tilt filter. No dependencies.
package ctf_pkg;

    // parameter defaults
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // CORDIC formats: inputs pre-scaled by 2^24, table in Q.24 degrees
    localparam int TABLE_LEN  = 24;
    localparam int TABLE_FRAC = 24;
    localparam int CX_W       = 44;   // x/y datapath width
    localparam int CZ_W       = 36;   // angle accumulator width

    localparam logic signed [CZ_W-1:0] Z_HALF_TURN = 36'sd3019898880;  // 180 deg Q.24

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 4'd1;
    localparam logic [15:0] ALPHA_RESET = 16'd64763;
    localparam logic [23:0] GAIN_RESET  = 24'd327680;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;   // latch sample
        logic init;      // load CORDIC vector for channel
        logic iterate;   // one CORDIC micro-rotation
        logic gyro;      // round CORDIC angle, form rate*gain
        logic mix_a;     // alpha * (angle + step)
        logic mix_b;     // (1 - alpha) * accel angle
        logic mix_c;     // sum, round, saturate, write state
        logic load_out;  // load output word
        logic ch;        // 0: xz channel, 1: yz channel
    } t_cmd;

    // atan(2^-i) in Q.24 degrees
    function automatic logic signed [CZ_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:  v = 36'sd754974720;
            5'd1:  v = 36'sd445687602;
            5'd2:  v = 36'sd235489088;
            5'd3:  v = 36'sd119537938;
            5'd4:  v = 36'sd60000934;
            5'd5:  v = 36'sd30029717;
            5'd6:  v = 36'sd15018523;
            5'd7:  v = 36'sd7509720;
            5'd8:  v = 36'sd3754917;
            5'd9:  v = 36'sd1877466;
            5'd10: v = 36'sd938734;
            5'd11: v = 36'sd469367;
            5'd12: v = 36'sd234684;
            5'd13: v = 36'sd117342;
            5'd14: v = 36'sd58671;
            5'd15: v = 36'sd29335;
            5'd16: v = 36'sd14668;
            5'd17: v = 36'sd7334;
            5'd18: v = 36'sd3667;
            5'd19: v = 36'sd1833;
            5'd20: v = 36'sd917;
            5'd21: v = 36'sd458;
            5'd22: v = 36'sd229;
            5'd23: v = 36'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/ctf_ctrl.sv =====
// ctf_ctrl: sequencer for the tilt filter; drives ctf_pkg::t_cmd to the
// datapath and owns the input stall and output valid. Uses ctf_pkg.
module ctf_ctrl #(
    parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF,
    parameter int IW           = $clog2(CORDIC_STEPS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ctf_pkg::t_cmd    o_cmd,
    output logic [IW-1:0]    o_iter
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_ITER = 3'd2;
    localparam logic [2:0] S_GYRO = 3'd3;
    localparam logic [2:0] S_MIXA = 3'd4;
    localparam logic [2:0] S_MIXB = 3'd5;
    localparam logic [2:0] S_MIXC = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_iter, n_iter;
    logic          r_ch, n_ch;
    logic          r_out_valid, n_out_valid;
    ctf_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_ch    = r_ch;
        cmd     = '0;
        cmd.ch  = r_ch;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_ch        = 1'b0;
                    n_state     = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init = 1'b1;
                n_iter   = '0;
                n_state  = S_ITER;
            end
            S_ITER: begin
                cmd.iterate = 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_GYRO;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_GYRO: begin
                cmd.gyro = 1'b1;
                n_state  = S_MIXA;
            end
            S_MIXA: begin
                cmd.mix_a = 1'b1;
                n_state   = S_MIXB;
            end
            S_MIXB: begin
                cmd.mix_b = 1'b1;
                n_state   = S_MIXC;
            end
            S_MIXC: begin
                cmd.mix_c = 1'b1;
                if (r_ch) begin
                    n_state = S_DONE;
                end else begin
                    n_ch    = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = cmd.load_out | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_iter      = r_iter;

`ifndef ASSERT_OFF
    // a waiting word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("output word overwritten while stalled");

    // an accepted sample starts the xz channel
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_INIT && !r_ch))
        else $error("accepted sample did not start CORDIC");

    // micro-rotations step through the table in order
    a_iter_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.iterate && r_iter != '0) |-> ($past(cmd.iterate) && $past(r_iter) == r_iter - 1'b1))
        else $error("CORDIC iteration skipped");

    // a loaded word is presented next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out_valid)
        else $error("loaded word not presented");
`endif

endmodule

// ===== hdl/ctf_datapath.sv =====
// ctf_datapath: sample latch, shared CORDIC unit, gyro multiplier, blend
// and saturation, angle state and output word. Uses ctf_pkg; driven by ctf_ctrl.
module ctf_datapath #(
    parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int IW              = $clog2(CORDIC_STEPS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ctf_pkg::t_cmd                     i_cmd,
    input  logic [IW-1:0]                     i_iter,
    input  logic                              i_cfg_valid,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ctf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [15:0]                i_accel_x,
    input  logic signed [15:0]                i_accel_y,
    input  logic signed [15:0]                i_accel_z,
    input  logic signed [15:0]                i_rate_x,
    input  logic signed [15:0]                i_rate_y,
    output logic signed [15:0]                o_xz_report,
    output logic signed [15:0]                o_yz_report
);

    localparam int CX_W  = ctf_pkg::CX_W;
    localparam int CZ_W  = ctf_pkg::CZ_W;
    localparam int ACC_W = 26;                              // CORDIC angle, Q.frac
    localparam int ZS    = ctf_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int GS    = 32 - ANGLE_FRAC_BITS;
    localparam logic signed [CZ_W-1:0] Z_RND = CZ_W'(1) << (ZS - 1);
    localparam logic signed [40:0]     P_RND = 41'(1) << (GS - 1);
    localparam logic signed [34:0]     LIM   = 35'(32767) << ANGLE_FRAC_BITS;

    // configuration
    logic [15:0] r_alpha;
    logic [23:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ctf_pkg::ALPHA_RESET;
            r_gain  <= ctf_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ctf_pkg::REG_ALPHA: r_alpha <= i_cfg_data[15:0];
                ctf_pkg::REG_GAIN:  r_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample latch
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_rate_x;
            r_gy <= i_rate_y;
        end
    end

    // CORDIC vector setup
    logic signed [16:0]     num, den, num_r, den_r;
    logic signed [CZ_W-1:0] z_init;
    logic                   both_zero;

    always_comb begin
        num       = i_cmd.ch ? 17'(r_ay) : 17'(r_ax);
        den       = 17'(r_az);
        both_zero = (num == '0) && (den == '0);
        if (den < 0) begin
            // rotate by 180 first; sign follows the numerator
            z_init = (num >= 0) ? ctf_pkg::Z_HALF_TURN : -ctf_pkg::Z_HALF_TURN;
            num_r  = -num;
            den_r  = -den;
        end else begin
            z_init = '0;
            num_r  = num;
            den_r  = den;
        end
    end

    // shared CORDIC iteration
    logic signed [CX_W-1:0] r_x, r_y, xs, ys;
    logic signed [CZ_W-1:0] r_z, at;
    logic                   r_zero;

    assign xs = r_x >>> i_iter;
    assign ys = r_y >>> i_iter;
    assign at = ctf_pkg::atan_q24(5'(i_iter));

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_x    <= CX_W'(den_r) <<< ctf_pkg::TABLE_FRAC;
            r_y    <= CX_W'(num_r) <<< ctf_pkg::TABLE_FRAC;
            r_z    <= z_init;
            r_zero <= both_zero;
        end else if (i_cmd.iterate) begin
            if (!r_y[CX_W-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
    end

    // angle rounding and gyro product
    logic signed [CZ_W-1:0]  z_rnd;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [40:0]      r_prod;
    logic signed [24:0]      gain_s;
    logic signed [15:0]      rate;

    assign z_rnd  = r_z + Z_RND;
    assign gain_s = signed'({1'b0, r_gain});
    assign rate   = i_cmd.ch ? r_gx : r_gy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.gyro) begin
            r_acc  <= r_zero ? '0 : ACC_W'(z_rnd >>> ZS);
            r_prod <= rate * gain_s;
        end
    end

    // blend products
    logic signed [31:0] r_xz, r_yz, angle;
    logic signed [40:0] p_rnd;
    logic signed [32:0] step, sum;
    logic signed [16:0] alpha_s;
    logic [16:0]        beta_u;
    logic signed [17:0] beta_s;
    logic signed [49:0] r_pa, pa;
    logic signed [43:0] r_pb, pb;

    assign angle   = i_cmd.ch ? r_yz : r_xz;
    assign p_rnd   = r_prod + P_RND;
    assign step    = 33'(p_rnd >>> GS);
    assign sum     = 33'(angle) + step;
    assign alpha_s = signed'({1'b0, r_alpha});
    assign beta_u  = 17'h10000 - {1'b0, r_alpha};
    assign beta_s  = signed'({1'b0, beta_u});
    assign pa      = alpha_s * sum;
    assign pb      = beta_s * r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_a) begin
            r_pa <= pa;
        end
        if (i_cmd.mix_b) begin
            r_pb <= pb;
        end
    end

    // sum, round half up, saturate
    logic signed [50:0] mix;
    logic signed [34:0] mix_r, mix_sat;

    always_comb begin
        mix   = 51'(r_pa) + 51'(r_pb) + 51'sd32768;
        mix_r = 35'(mix >>> 16);
        if (mix_r > LIM) begin
            mix_sat = LIM;
        end else if (mix_r < -LIM) begin
            mix_sat = -LIM;
        end else begin
            mix_sat = mix_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xz <= '0;
            r_yz <= '0;
        end else if (i_cmd.mix_c) begin
            if (i_cmd.ch) begin
                r_yz <= 32'(mix_sat);
            end else begin
                r_xz <= 32'(mix_sat);
            end
        end
    end

    // whole degrees, truncated toward zero
    logic [31:0] xz_mag, yz_mag, xz_whole, yz_whole;

    always_comb begin
        xz_mag   = r_xz[31] ? 32'(-r_xz) : 32'(r_xz);
        yz_mag   = r_yz[31] ? 32'(-r_yz) : 32'(r_yz);
        xz_whole = xz_mag >> ANGLE_FRAC_BITS;
        yz_whole = yz_mag >> ANGLE_FRAC_BITS;
        xz_whole = r_xz[31] ? -xz_whole : xz_whole;
        yz_whole = r_yz[31] ? -yz_whole : yz_whole;
    end

    // axes swapped on output
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_xz_report <= signed'(yz_whole[15:0]);
            o_yz_report <= signed'(xz_whole[15:0]);
        end
    end

endmodule

// ===== hdl/complementary_tilt_filter.sv =====
// complementary_tilt_filter: top level; CORDIC tilt angles blended with
// gyro rates. Instantiates ctf_ctrl and ctf_datapath; uses ctf_pkg.
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  ------------------------------------
//  sample    in         i_in_valid / o_in_stall     i_accel_x/y/z, i_rate_x, i_rate_y
//  report    out        o_out_valid / i_out_stall   o_xz_report, o_yz_report
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Per sample, one shared CORDIC unit is run first for the xz angle, then for the
//   yz angle, each run followed by the gyro multiply, the blend multiplies and
//   saturation (S_GYRO, S_MIXA, S_MIXB, S_MIXC).
// One sample in flight; o_in_stall is high from accept until the word is loaded.
// The report register frees the core: a new sample is taken while a word waits;
//   a finished word waits in the core only if the previous one is still stalled.
// Reset (synchronous, active low) zeroes both angles and restores the defaults
//   of blend_alpha and gyro_step_gain. Config writes are always ready.
module complementary_tilt_filter #(
    parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [15:0]                i_accel_x,
    input  logic signed [15:0]                i_accel_y,
    input  logic signed [15:0]                i_accel_z,
    input  logic signed [15:0]                i_rate_x,
    input  logic signed [15:0]                i_rate_y,
    // report channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [15:0]                o_xz_report,
    output logic signed [15:0]                o_yz_report,
    // config channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ctf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IW = $clog2(CORDIC_STEPS);

    ctf_pkg::t_cmd  cmd;
    logic [IW-1:0]  iter;

    // registers are plain flops: a write lands every cycle it is offered
    assign o_cfg_ready = 1'b1;

    ctf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .IW           (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_iter      (iter)
    );

    ctf_datapath #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .IW              (IW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_iter      (iter),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_rate_x    (i_rate_x),
        .i_rate_y    (i_rate_y),
        .o_xz_report (o_xz_report),
        .o_yz_report (o_yz_report)
    );

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for complementary_tilt_filter.
// Directed table, then random phases, checked against a built-in filter predictor or typed results.
// Depends on ctf_pkg and complementary_tilt_filter (hdl/).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Predictor formats: angles are Q.16 degrees. The CORDIC runs on inputs
    // scaled by 2^24, and its table is in Q.24 degrees.
    // ------------------------------------------------------------------
    localparam int     STEPS     = ctf_pkg::CORDIC_STEPS_DEF;
    localparam int     FRAC      = ctf_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int     IDX_W     = ctf_pkg::CFG_IDX_W;
    localparam int     DATA_W    = ctf_pkg::CFG_DATA_W;
    localparam longint HALF_TURN = 64'sd3019898880;             // 180 deg, Q.24
    localparam longint SAT_LIM   = 64'sd32767 * 64'sd65536;     // +-32767 deg, Q.16

    // atan(2^-i) in Q.24 degrees
    longint atan_deg [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;     // drives the yz angle
        logic signed [15:0] gy;     // drives the xz angle
    } t_imu_word;

    typedef struct packed {
        logic signed [15:0] xz;
        logic signed [15:0] yz;
    } t_report;

    typedef enum logic { ROW_WORD, ROW_REG } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_imu_word          word;
        bit                 known;      // result typed in the table
        t_report            want;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  data;
    } t_dir_row;

    typedef enum int { GEN_MIX, GEN_DRIFT_UP, GEN_DRIFT_DOWN } t_gen_mode;

    // ------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic signed [15:0]     i_accel_x   = '0;
    logic signed [15:0]     i_accel_y   = '0;
    logic signed [15:0]     i_accel_z   = '0;
    logic signed [15:0]     i_rate_x    = '0;
    logic signed [15:0]     i_rate_y    = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [15:0]     o_xz_report;
    logic signed [15:0]     o_yz_report;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [IDX_W-1:0]       i_cfg_index = '0;
    logic [DATA_W-1:0]      i_cfg_data  = '0;

    complementary_tilt_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_rate_x    (i_rate_x),
        .i_rate_y    (i_rate_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_xz_report (o_xz_report),
        .o_yz_report (o_yz_report),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers and both angles
    // ------------------------------------------------------------------
    logic [15:0]        alpha_reg = ctf_pkg::ALPHA_RESET;
    logic [23:0]        gain_reg  = ctf_pkg::GAIN_RESET;
    logic signed [31:0] xz_tilt   = '0;
    logic signed [31:0] yz_tilt   = '0;

    t_report  report_q [$];         // predicted report words, oldest first
    t_dir_row dir_rows [$];

    int  n_err      = 0;
    int  n_sent     = 0;
    int  n_recv     = 0;
    int  n_regs     = 0;
    int  n_sat      = 0;
    int  burst_left = 0;
    bit  valid_on   = 1'b0;         // shadow of i_in_valid as last driven

    // Round from 'from_bits' fraction bits down to Q.16, half up.
    function automatic longint to_angle(input longint v, input int from_bits);
        int s;
        s = from_bits - FRAC;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Vectoring CORDIC atan2(num, den) in Q.16 degrees.
    function automatic longint tilt_deg(input longint num_in, input longint den_in);
        longint num, den, x, y, z, xs, ys;
        num = num_in;
        den = den_in;
        z   = 0;
        if (num == 0 && den == 0)
            return 0;
        // left half plane: rotate by 180 first, sign set by the numerator
        if (den < 0) begin
            z   = (num >= 0) ? HALF_TURN : -HALF_TURN;
            den = -den;
            num = -num;
        end
        x = den <<< 24;
        y = num <<< 24;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_deg[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_deg[i];
            end
        end
        return to_angle(z, 24);
    endfunction

    // alpha*(angle + rate*gain) + (1-alpha)*accel angle, rounded and clamped
    function automatic logic signed [31:0] blend_angle(input logic signed [31:0] angle,
                                                       input logic signed [15:0] rate,
                                                       input longint acc);
        longint gyro_inc, mix_sum, a, mix, r;
        gyro_inc = to_angle(longint'(rate) * longint'(gain_reg), 32);
        mix_sum  = longint'(angle) + gyro_inc;
        a        = longint'(alpha_reg);
        mix      = a * mix_sum + (64'sd65536 - a) * acc;
        r        = (mix + 64'sd32768) >>> 16;
        if (r > SAT_LIM) begin
            r = SAT_LIM;
            n_sat++;
        end else if (r < -SAT_LIM) begin
            r = -SAT_LIM;
            n_sat++;
        end
        return r[31:0];
    endfunction

    // Q.16 to whole degrees, truncated toward zero
    function automatic logic signed [15:0] whole_deg(input logic signed [31:0] angle);
        longint v, w;
        v = angle;
        w = (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
        return w[15:0];
    endfunction

    // One sample into the predictor; note the axis swap on the way out.
    function automatic t_report advance_filter(input t_imu_word w);
        t_report r;
        xz_tilt = blend_angle(xz_tilt, w.gy, tilt_deg(w.ax, w.az));
        yz_tilt = blend_angle(yz_tilt, w.gx, tilt_deg(w.ay, w.az));
        r.xz = whole_deg(yz_tilt);
        r.yz = whole_deg(xz_tilt);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        n_err++;
        if (n_err <= 40)
            $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic t_imu_word mk_word(input int ax, ay, az, gx, gy);
        t_imu_word w;
        w.ax = ax[15:0];
        w.ay = ay[15:0];
        w.az = az[15:0];
        w.gx = gx[15:0];
        w.gy = gy[15:0];
        return w;
    endfunction

    function automatic void add_word(input int ax, ay, az, gx, gy);
        t_dir_row row;
        row = '{kind: ROW_WORD, word: mk_word(ax, ay, az, gx, gy), known: 1'b0,
                want: '0, idx: '0, data: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_known(input int ax, ay, az, gx, gy, input int xz, yz);
        t_dir_row row;
        row = '{kind: ROW_WORD, word: mk_word(ax, ay, az, gx, gy), known: 1'b1,
                want: {xz[15:0], yz[15:0]}, idx: '0, data: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(input int idx, input int data);
        t_dir_row row;
        row = '{kind: ROW_REG, word: '0, known: 1'b0, want: '0,
                idx: idx[IDX_W-1:0], data: data[DATA_W-1:0]};
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Random sample words
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] rand_span(input int lo, input int hi);
        int r;
        r = lo + int'($urandom_range(0, hi - lo));
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] corner16();
        case ($urandom_range(0, 5))
            0:       return 16'sd0;
            1:       return 16'sd1;
            2:       return -16'sd1;
            3:       return 16'sh7FFF;
            4:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_imu_word gen_word(input t_gen_mode mode);
        t_imu_word w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // board near level, either side up, modest rotation
            w.az = ($urandom_range(0, 3) == 0) ? rand_span(-17000, -8000)
                                                : rand_span(8000, 17000);
            w.ax = rand_span(-12000, 12000);
            w.ay = rand_span(-12000, 12000);
            w.gx = rand_span(-3000, 3000);
            w.gy = rand_span(-3000, 3000);
        end else if (pick < 75) begin
            w = 80'({$urandom, $urandom, $urandom});
        end else if (pick < 90) begin
            w = {corner16(), corner16(), corner16(), corner16(), corner16()};
        end else begin
            // zero z axis, sometimes zero numerators too
            w    = 80'({$urandom, $urandom, $urandom});
            w.az = '0;
            if ($urandom_range(0, 1)) w.ax = '0;
            if ($urandom_range(0, 1)) w.ay = '0;
        end
        // drift phases hold the gyros near full scale to walk into saturation
        if (mode != GEN_MIX && $urandom_range(0, 99) < 95) begin
            w.gx = (mode == GEN_DRIFT_UP) ? 16'sh7FFF : 16'sh8000;
            w.gy = (mode == GEN_DRIFT_UP) ? 16'sh7FFF : 16'sh8000;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender side: bursts with random gaps between them
    // ------------------------------------------------------------------
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                valid_on = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_word(input t_imu_word w, input bit known, input t_report want);
        t_report pred;
        i_in_valid <= 1'b1;
        valid_on = 1'b1;
        i_accel_x <= w.ax;
        i_accel_y <= w.ay;
        i_accel_z <= w.az;
        i_rate_x  <= w.gx;
        i_rate_y  <= w.gy;
        do @(posedge i_clk); while (o_in_stall);
        pred = advance_filter(w);   // advance state even for typed rows
        report_q.push_back(known ? want : pred);
        n_sent++;
        pace_sender();
    endtask

    // Register write, only once the block has drained every word.
    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        if (valid_on) begin
            i_in_valid <= 1'b0;
            valid_on = 1'b0;
        end
        while (report_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            ctf_pkg::REG_ALPHA: alpha_reg = data[15:0];
            ctf_pkg::REG_GAIN:  gain_reg  = data;
            default:            ;        // unknown index: no effect
        endcase
        n_regs++;
    endtask

    task automatic run_phase(input int alpha, input int gain, input t_gen_mode mode,
                             input int count);
        // a stray write to an unused index first, it must change nothing
        write_reg(IDX_W'($urandom_range(2, 15)), DATA_W'($urandom));
        write_reg(ctf_pkg::REG_ALPHA, alpha[DATA_W-1:0]);
        write_reg(ctf_pkg::REG_GAIN, gain[DATA_W-1:0]);
        repeat (count) send_word(gen_word(mode), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall pattern of its own, in modes of random length:
    // never stall, random stalls, or long stall runs.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_pace
        int stall_mode;
        int mode_left;
        int run_left;
        bit hold;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 35);
            default: begin
                if (run_left == 0) begin
                    hold     = !hold;
                    run_left = hold ? $urandom_range(20, 90) : $urandom_range(1, 12);
                end else begin
                    run_left--;
                end
                i_out_stall <= hold;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Report checker: each accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : report_check
        t_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_recv++;
            if (report_q.size() == 0) begin
                flag_mismatch("report word with nothing pending", 0, o_xz_report);
            end else begin
                want = report_q.pop_front();
                if (o_xz_report !== want.xz)
                    flag_mismatch("o_xz_report", want.xz, o_xz_report);
                if (o_yz_report !== want.yz)
                    flag_mismatch("o_yz_report", want.yz, o_yz_report);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int settle;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset both angles are zero and atan2(0,0) is zero
        add_known(0, 0, 0, 0, 0, 0, 0);
        add_known(0, 0, 0, 0, 0, 0, 0);
        add_word(32767, -32768, 0, 0, 0);             // +90 and -90
        add_word(0, 0, -32768, 0, 0);                 // atan2(0, negative) is +180
        add_word(-1, 1, -1, 1, -1);                   // negative z, sign from numerator
        add_word(-32768, -32768, -32768, -32768, -32768);
        add_word(32767, 32767, 32767, 32767, 32767);
        add_word(1, -1, 32767, -32768, 32767);
        add_word(-32768, 32767, 1, 0, 0);
        // alpha zero: only the accelerometer angle is left, zero here
        add_reg(int'(ctf_pkg::REG_ALPHA), 0);
        add_known(0, 0, 0, 32767, -32768, 0, 0);
        add_word(-32768, 12345, -1, 32767, 32767);
        add_word(100, -100, 50, 0, 0);
        // full gain, and alpha from a word whose upper bits must be dropped
        add_reg(int'(ctf_pkg::REG_GAIN), 24'hFFFFFF);
        add_reg(int'(ctf_pkg::REG_ALPHA), 24'hFFFFFF);
        add_word(0, 0, 16384, 32767, -32768);
        add_word(0, 0, 16384, 32767, -32768);
        add_word(0, 0, 16384, 32767, -32768);
        add_reg(4'hF, 0);                             // unused indexes are ignored
        add_reg(4'h2, 24'h5A5A5A);
        add_word(-20000, 20000, -5, -32768, 32767);
        add_reg(int'(ctf_pkg::REG_ALPHA), int'(ctf_pkg::ALPHA_RESET));
        add_reg(int'(ctf_pkg::REG_GAIN), 0);          // gyros have no effect
        add_word(5000, -5000, 12000, 32767, -32768);
        add_reg(int'(ctf_pkg::REG_GAIN), int'(ctf_pkg::GAIN_RESET));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG)
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            else
                send_word(dir_rows[k].word, dir_rows[k].known, dir_rows[k].want);
        end

        // random phases over several register settings, extremes included
        run_phase(int'(ctf_pkg::ALPHA_RESET), int'(ctf_pkg::GAIN_RESET), GEN_MIX, 200);
        run_phase(0, $urandom & 24'hFFFFFF, GEN_MIX, 200);
        run_phase(65535, 24'hFFFFFF, GEN_DRIFT_UP, 300);      // to +32767 deg
        run_phase(65535, 24'hFFFFFF, GEN_DRIFT_DOWN, 640);    // through to -32767 deg
        run_phase($urandom_range(0, 65535), $urandom & 24'hFFFFFF, GEN_MIX, 200);
        run_phase(1, 1, GEN_MIX, 200);
        run_phase($urandom_range(60000, 65535), $urandom_range(0, 1000000), GEN_MIX, 200);

        if (valid_on) begin
            i_in_valid <= 1'b0;
            valid_on = 1'b0;
        end
        while (report_q.size() != 0) @(posedge i_clk);
        // catch any extra word the block might still put out
        settle = 2 * STEPS + 40;
        repeat (settle) @(posedge i_clk);

        $display("Covered %0d sample words, %0d report words and %0d register writes.",
                 n_sent, n_recv, n_regs);
        $display("Blended angles clamped at the limit %0d times; %0d mismatches.",
                 n_sat, n_err);
        if (n_err == 0)
            $display("** complementary_tilt_filter: PASSED **");
        else
            $display("** complementary_tilt_filter: FAILED **");
        $finish;
    end

    // Hard stop, several times the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("Timed out with %0d report words still pending.", report_q.size());
        $display("** complementary_tilt_filter: FAILED **");
        $finish;
    end

endmodule
